[src/ers_pkg.sv]
// Shared types and constants for the enumeration rank sort block.
// No dependencies; imported by ers_rank_unit and enumeration_rank_sort_top.
package ers_pkg;

	// Default batch capacity.
	localparam int MAX_ITEMS_DEF = 16;

	// Data width of one element.
	localparam int VAL_W = 32;

	// Width of the original index result field.
	localparam int IDX_OUT_W = 6;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_LOAD  = 5'b00001,
		S_FETCH = 5'b00010,
		S_LATCH = 5'b00100,
		S_SCAN  = 5'b01000,
		S_PLACE = 5'b10000
	} seq_state_t;

	// Control from the sequencer to the rank unit.
	typedef struct packed {
		logic clear;
		logic valid;
	} rank_ctl_t;

endpackage

[src/enumeration_rank_sort_top.sv]
// After the transfer of the final item, every element is ranked and placed; the n results
// of a batch of n items then follow on consecutive cycles.
// All ranking uses the single shared comparator, which makes n*n comparisons per batch.
// busy stays high from the transfer of the final item until the last result.
// Reset clears the sequencer and item count; the element memories are not cleared.
// Results cannot be stalled by the receiver. Depends on ers_pkg and ers_rank_unit.
module enumeration_rank_sort_top #(
	parameter int MAX_ITEMS = ers_pkg::MAX_ITEMS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [ers_pkg::VAL_W-1:0]        value,
	input  logic                                    is_last,
	output logic                                    strobe,
	output logic signed [ers_pkg::VAL_W-1:0]        sorted_value,
	output logic [ers_pkg::IDX_OUT_W-1:0]           original_index,
	output logic                                    last_out
);
	import ers_pkg::*;

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam logic [IDX_W-1:0] FULL_IDX = IDX_W'(MAX_ITEMS - 1);

	seq_state_t       state_q;
	logic [IDX_W-1:0] count_q;
	logic [IDX_W-1:0] last_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic             accept;
	logic             emit_q;

	logic signed [VAL_W-1:0] value_mem [MAX_ITEMS];
	logic signed [VAL_W-1:0] value_rd_q;
	logic signed [VAL_W-1:0] vi_q;
	logic [IDX_W-1:0]        rd_addr;

	logic signed [VAL_W-1:0] sorted_mem [MAX_ITEMS];
	logic [IDX_W-1:0]        index_mem  [MAX_ITEMS];
	logic signed [VAL_W-1:0] sorted_rd_q;
	logic [IDX_W-1:0]        index_rd_q;

	logic             cmp_v_s1;
	logic [IDX_W-1:0] cmp_j_s1;
	rank_ctl_t        rank_ctl;
	logic [IDX_W-1:0] rank;

	logic             strobe_q;
	logic             last_out_q;

	assign busy   = (state_q != S_LOAD) || emit_q;
	assign accept = start && !busy;

	// Value memory read address: element i while fetching, else the scan index.
	assign rd_addr = (state_q == S_FETCH) ? i_q : j_q;

	// Value memory: written on each input transfer, registered read.
	always_ff @(posedge clk) begin
		if (accept) begin
			value_mem[count_q] <= value;
		end
		value_rd_q <= value_mem[rd_addr];
	end

	// Sorted memories: written at the rank of each element, read in order while emitting.
	always_ff @(posedge clk) begin
		if (state_q == S_PLACE) begin
			sorted_mem[rank] <= vi_q;
			index_mem[rank]  <= i_q;
		end
		sorted_rd_q <= sorted_mem[i_q];
		index_rd_q  <= index_mem[i_q];
	end

	// Element under ranking, latched once per element.
	always_ff @(posedge clk) begin
		if (state_q == S_LATCH) begin
			vi_q <= value_rd_q;
		end
	end

	// Rank unit control.
	always_comb begin
		rank_ctl.clear = (state_q == S_LATCH);
		rank_ctl.valid = cmp_v_s1;
	end

	ers_rank_unit #(
		.IDX_W (IDX_W)
	) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rank_ctl),
		.vi     (vi_q),
		.vj     (value_rd_q),
		.i      (i_q),
		.j      (cmp_j_s1),
		.rank   (rank)
	);

	// Sequencer: load, then rank every element, then emit in sorted order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			last_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			emit_q     <= 1'b0;
			cmp_v_s1   <= 1'b0;
			cmp_j_s1   <= '0;
			strobe_q   <= 1'b0;
			last_out_q <= 1'b0;
		end else begin
			cmp_v_s1   <= (state_q == S_LATCH) || (state_q == S_SCAN);
			cmp_j_s1   <= j_q;
			strobe_q   <= emit_q;
			last_out_q <= emit_q && (i_q == last_q);
			if (emit_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == last_q) begin
					emit_q <= 1'b0;
				end
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (is_last || (count_q == FULL_IDX)) begin
							last_q  <= count_q;
							count_q <= '0;
							i_q     <= '0;
							state_q <= S_FETCH;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_FETCH: begin
					j_q     <= '0;
					state_q <= S_LATCH;
				end
				S_LATCH: begin
					j_q     <= j_q + 1'b1;
					state_q <= (last_q == '0) ? S_PLACE : S_SCAN;
				end
				S_SCAN: begin
					j_q <= j_q + 1'b1;
					if (j_q == last_q) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					if (i_q == last_q) begin
						i_q     <= '0;
						emit_q  <= 1'b1;
						state_q <= S_LOAD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_FETCH;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign strobe         = strobe_q;
	assign sorted_value   = sorted_rd_q;
	assign original_index = IDX_OUT_W'(index_rd_q);
	assign last_out       = last_out_q;

	// The final result of a batch is never directly followed by another.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_out) |=> !strobe)
		else $error("result directly after end of batch");

	// Every result but the final one is delivered while the block is busy.
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_out) |-> busy)
		else $error("result transfer while idle");

	// A rank never points past the loaded batch.
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE) |-> (rank <= last_q))
		else $error("rank beyond batch size");

endmodule

[src/ers_rank_unit.sv]
// Shared comparator and rank accumulator for the enumeration rank sort.
// Depends on ers_pkg.
module ers_rank_unit #(
	parameter int IDX_W = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ers_pkg::rank_ctl_t                  ctl,
	input  logic signed [ers_pkg::VAL_W-1:0]    vi,
	input  logic signed [ers_pkg::VAL_W-1:0]    vj,
	input  logic [IDX_W-1:0]                    i,
	input  logic [IDX_W-1:0]                    j,
	output logic [IDX_W-1:0]                    rank
);
	import ers_pkg::*;

	logic [IDX_W-1:0] rank_q;
	logic             inc;

	// A smaller value, or an equal value loaded earlier, pushes the rank up.
	always_comb begin
		inc = ctl.valid && ((vj < vi) || ((vj == vi) && (j < i)));
	end

	assign rank = rank_q + IDX_W'(inc);

	// Rank accumulator, cleared at the start of each element.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else if (ctl.clear) begin
			rank_q <= '0;
		end else begin
			rank_q <= rank;
		end
	end

	// Clear and a comparison never fall in the same cycle.
	a_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |-> !ctl.valid)
		else $error("rank clear overlaps a comparison");

	// After a clear the accumulator starts from zero.
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> rank_q == '0)
		else $error("rank not cleared");

	// An element is never counted against itself.
	a_no_self: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.valid && (i == j)) |-> !inc)
		else $error("element counted against itself");

endmodule
